### src/spool_pkg.sv
// Shared types and constants for the slot pool with ordered active list.
package spool_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = 6;   // holds any slot number up to MAX_SLOTS-1
  localparam int CNT_W     = 7;   // holds a list length up to MAX_SLOTS

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FIND  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_USED  = 2'd2,
    ST_END   = 2'd3
  } status_t;

  // Broadcast from the control to every list cell.
  typedef struct packed {
    logic  do_alloc;
    logic  do_free;
    slot_t slot;
    cnt_t  total;
    cnt_t  rd_pos;
  } cell_ctl_t;

endpackage

### src/spool_if.sv
// Channel interfaces for operation beats and result beats.
interface spool_in_if import spool_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               op;
  logic [7:0]        slot_index;
  logic signed [4:0] cursor;

  modport source (output valid, op, slot_index, cursor, input ready);
  modport sink   (input valid, op, slot_index, cursor, output ready);
endinterface

interface spool_out_if import spool_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [2:0]        found_slot;
  logic signed [4:0] next_cursor;
  logic [3:0]        active_count;

  modport source (output valid, status, found_slot, next_cursor, active_count, input ready);
  modport sink   (input valid, status, found_slot, next_cursor, active_count, output ready);
endinterface

### src/spool_cell.sv
// One position of the active list: holds a slot number, matches, shifts and reads.
module spool_cell import spool_pkg::*; #(
  parameter int POS = 0
) (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  slot_t     nbr_entry,   // entry of the next position up
  input  logic      seen_in,     // a lower position already matched
  output logic      seen_out,
  input  slot_t     rd_in,
  output slot_t     rd_out,
  output slot_t     entry
);

  slot_t entry_r;
  logic  live;
  logic  hit;
  logic  at_pos;

  function automatic logic at_tail();
    at_tail = CNT_W'(POS) == ctl.total;
  endfunction

  assign live     = CNT_W'(POS) < ctl.total;
  assign hit      = live && (entry_r == ctl.slot);
  assign seen_out = seen_in | hit;
  assign at_pos   = CNT_W'(POS) == ctl.rd_pos;
  assign rd_out   = rd_in | (at_pos ? entry_r : '0);
  assign entry    = entry_r;

  always_ff @(posedge clk) begin
    if (ctl.do_alloc && at_tail()) begin
      entry_r <= ctl.slot;
    end else if (ctl.do_free && seen_out) begin
      // close the gap: take the neighbor's entry from the match upward
      entry_r <= nbr_entry;
    end
  end

endmodule

### src/slot_pool_ordered_active_list.sv
// Top level: slot pool with used marks and an ordered active list in a row of cells.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        op, slot_index, cursor
//   out_ch    out   valid/ready        status, found_slot, next_cursor, active_count
//
// Each operation first registers the beat, then runs it through
// the cell row (match, shift, append or read), which loads the result register.
// A new beat is taken once the previous one has executed.
// Execution waits while a finished result is still held on out_ch.
// rst_n (synchronous) empties the pool; list entries need no clearing.
module slot_pool_ordered_active_list import spool_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  spool_in_if.sink    in_ch,
  spool_out_if.source out_ch
);

  localparam int IW = $clog2(SLOTS);

  // registered operation
  logic              busy_r;
  op_t               op_r;
  logic [7:0]        idx_r;
  logic signed [4:0] cur_r;

  // pool state
  logic [SLOTS-1:0] used_r, used_nxt;
  cnt_t             total_r, total_nxt;

  // result register
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [2:0]        slot_out_r;
  logic signed [4:0] next_out_r, next_nxt;
  logic [3:0]        count_out_r;

  logic      exec_fire;
  logic      in_range;
  logic      is_start;
  logic      early_end;
  cnt_t      find_pos;
  slot_t     slot_res;
  cell_ctl_t ctl;

  logic  seen_chain [SLOTS+1];
  slot_t rd_chain   [SLOTS+1];
  slot_t entry_w    [SLOTS+1];

  assign in_ch.ready = !busy_r;
  assign exec_fire   = busy_r && (!out_valid_r || out_ch.ready);

  assign in_range  = {1'b0, idx_r} < 9'(SLOTS);
  assign is_start  = cur_r == -5'sd1;
  assign early_end = !is_start && (cur_r[4] || (CNT_W'(cur_r[3:0]) >= total_r));
  assign find_pos  = is_start ? '0 : CNT_W'(cur_r[3:0]) + CNT_W'(1);

  // a free with no match shifts nothing, so the cells need no found flag
  assign ctl = '{
    do_alloc: (op_r == OP_ALLOC) && in_range && !used_r[idx_r[IW-1:0]] && exec_fire,
    do_free:  (op_r == OP_FREE) && in_range && exec_fire,
    slot:     idx_r[SLOT_W-1:0],
    total:    total_r,
    rd_pos:   find_pos
  };

  assign seen_chain[0] = 1'b0;
  assign rd_chain[0]   = '0;
  assign entry_w[SLOTS] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    spool_cell #(.POS(g)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .nbr_entry (entry_w[g+1]),
      .seen_in   (seen_chain[g]),
      .seen_out  (seen_chain[g+1]),
      .rd_in     (rd_chain[g]),
      .rd_out    (rd_chain[g+1]),
      .entry     (entry_w[g])
    );
  end

  always_comb begin
    status_nxt = ST_OK;
    slot_res   = '0;
    next_nxt   = '0;
    total_nxt  = total_r;
    used_nxt   = used_r;
    unique case (op_r)
      OP_ALLOC: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (used_r[idx_r[IW-1:0]]) begin
          status_nxt = ST_USED;
        end else begin
          used_nxt[idx_r[IW-1:0]] = 1'b1;
          total_nxt               = total_r + CNT_W'(1);
          slot_res                = idx_r[SLOT_W-1:0];
        end
      end
      OP_FREE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (!seen_chain[SLOTS]) begin
          status_nxt = ST_END;
        end else begin
          used_nxt[idx_r[IW-1:0]] = 1'b0;
          total_nxt               = total_r - CNT_W'(1);
          slot_res                = idx_r[SLOT_W-1:0];
        end
      end
      OP_FIND: begin
        if (early_end) begin
          status_nxt = ST_END;
          next_nxt   = cur_r;
        end else if (find_pos < total_r) begin
          slot_res = rd_chain[SLOTS];
          next_nxt = find_pos[4:0];
        end else begin
          status_nxt = ST_END;
          next_nxt   = total_r[4:0];
        end
      end
      OP_CLEAR: begin
        total_nxt = '0;
        used_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      total_r     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        busy_r <= 1'b1;
      end else if (exec_fire) begin
        busy_r <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
        used_r      <= used_nxt;
        total_r     <= total_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.op;
      idx_r <= in_ch.slot_index;
      cur_r <= in_ch.cursor;
    end
    if (exec_fire) begin
      status_r    <= status_nxt;
      slot_out_r  <= slot_res[2:0];
      next_out_r  <= next_nxt;
      count_out_r <= total_nxt[3:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.found_slot   = slot_out_r;
  assign out_ch.next_cursor  = next_out_r;
  assign out_ch.active_count = count_out_r;

`ifndef SYNTH
  a_count_matches_marks: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(used_r)) == total_r)
    else $error("list length differs from number of used marks");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(SLOTS))
    else $error("list length beyond pool size");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_valid_r && !out_ch.ready) |=> ($stable(total_r) && $stable(used_r)))
    else $error("pool state changed while result stalled");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> (out_valid_r && !busy_r))
    else $error("executed beat produced no result");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the slot pool with ordered active list.
module testbench import spool_pkg::*; ();

  localparam int POOL_SLOTS  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    status_t           status;
    logic [2:0]        slot;
    logic signed [4:0] cursor;
    logic [3:0]        count;
  } pool_result_t;

  logic clk;
  logic rst_n;

  spool_in_if  in_ch ();
  spool_out_if out_ch ();

  slot_pool_ordered_active_list #(.SLOTS(POOL_SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the pool contents
  bit           slot_used [POOL_SLOTS];
  logic [2:0]   list_order [POOL_SLOTS];
  int           list_len;

  pool_result_t pending_results [$];
  pool_result_t last_result;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           stall_hold = 0;
  bit           hold_toggle = 1'b0;
  bit           hold_seen = 1'b0;
  bit           calm;
  logic signed [4:0] walk_pos;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic pool_result_t apply_pool_op(input op_t op, input logic [7:0] idx,
                                                 input logic signed [4:0] cur);
    pool_result_t r;
    int           hit;
    int           nxt;
    r = '{ST_OK, 3'd0, 5'sd0, 4'd0};
    hit = -1;
    case (op)
      OP_ALLOC: begin
        if (idx >= POOL_SLOTS) r.status = ST_RANGE;
        else if (slot_used[idx[2:0]]) r.status = ST_USED;
        else begin
          slot_used[idx[2:0]] = 1'b1;
          if (list_len < POOL_SLOTS) begin
            list_order[list_len] = idx[2:0];
            list_len++;
          end
          r.slot = idx[2:0];
        end
      end
      OP_FREE: begin
        if (idx >= POOL_SLOTS) r.status = ST_RANGE;
        else begin
          for (int i = list_len - 1; i >= 0; i--)
            if (list_order[i] == idx[2:0]) hit = i;
          if (hit < 0) r.status = ST_END;
          else begin
            // close the gap behind the removed entry
            list_len--;
            for (int i = hit; i < list_len; i++) list_order[i] = list_order[i + 1];
            slot_used[idx[2:0]] = 1'b0;
            r.slot = idx[2:0];
          end
        end
      end
      OP_FIND: begin
        if (cur != -1 && (cur < 0 || cur >= list_len)) begin
          r.status = ST_END;
          r.cursor = cur;
        end else begin
          nxt = cur + 1;
          if (nxt < list_len) begin
            r.slot   = list_order[nxt];
            r.cursor = 5'(nxt);
          end else begin
            r.status = ST_END;
            r.cursor = 5'(list_len);
          end
        end
      end
      default: begin
        for (int i = 0; i < POOL_SLOTS; i++) slot_used[i] = 1'b0;
        list_len = 0;
      end
    endcase
    r.count = 4'(list_len);
    return r;
  endfunction

  // Offer one beat, with random gaps ahead of it, and predict it on acceptance.
  task automatic send_op(input op_t op, input logic [7:0] idx, input logic signed [4:0] cur);
    while (!calm && $urandom_range(99) < 22) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.slot_index <= idx;
    in_ch.cursor     <= cur;
    do @(posedge clk); while (!in_ch.ready);
    last_result = apply_pool_op(op, idx, cur);
    pending_results.push_back(last_result);
  endtask

  // Drop valid so the last beat is not offered again, then wait for all results.
  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, calm stretches, and a counted hold-off.
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen  = hold_toggle;
      stall_hold = HOLD_CYCLES;
    end
    if (stall_hold > 0) begin
      out_ch.ready <= 1'b0;
      stall_hold--;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.found_slot !== want.slot)
          report_mismatch($sformatf("found_slot %0d, want %0d", out_ch.found_slot, want.slot));
        if (out_ch.next_cursor !== want.cursor)
          report_mismatch($sformatf("next_cursor %0d, want %0d",
                                    out_ch.next_cursor, want.cursor));
        if (out_ch.active_count !== want.count)
          report_mismatch($sformatf("active_count %0d, want %0d",
                                    out_ch.active_count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic test_empty_pool();
    send_op(OP_FIND, 8'd0, -5'sd1);
    send_op(OP_FREE, 8'd3, 5'sd0);
  endtask

  task automatic test_alloc_limits();
    send_op(OP_ALLOC, 8'd0, 5'sd0);
    send_op(OP_ALLOC, 8'd7, 5'sd0);
    send_op(OP_ALLOC, 8'd8, 5'sd0);
    send_op(OP_ALLOC, 8'd255, -5'sd16);
    send_op(OP_ALLOC, 8'd0, 5'sd15);
  endtask

  task automatic test_find_walk();
    send_op(OP_FIND, 8'd0, -5'sd1);
    send_op(OP_FIND, 8'd0, 5'sd0);
    send_op(OP_FIND, 8'd0, 5'sd1);
    send_op(OP_FIND, 8'd255, 5'sd15);
    send_op(OP_FIND, 8'd0, -5'sd16);
    send_op(OP_FIND, 8'd0, -5'sd2);
  endtask

  task automatic test_free_order();
    send_op(OP_ALLOC, 8'd3, 5'sd0);
    send_op(OP_ALLOC, 8'd5, 5'sd0);
    send_op(OP_FREE, 8'd7, 5'sd0);
    send_op(OP_FREE, 8'd200, 5'sd0);
    send_op(OP_FREE, 8'd7, 5'sd0);
    send_op(OP_FIND, 8'd0, 5'sd0);
  endtask

  task automatic test_fill_and_clear();
    send_op(OP_ALLOC, 8'd1, 5'sd0);
    send_op(OP_ALLOC, 8'd2, 5'sd0);
    send_op(OP_ALLOC, 8'd4, 5'sd0);
    send_op(OP_ALLOC, 8'd6, 5'sd0);
    send_op(OP_ALLOC, 8'd7, 5'sd0);
    send_op(OP_FIND, 8'd0, 5'sd7);
    send_op(OP_CLEAR, 8'd255, -5'sd1);
    send_op(OP_FIND, 8'd0, -5'sd1);
  endtask

  // Hold the result side while beats keep coming, then drain fully.
  task automatic test_backpressure();
    wait_results_drained();
    hold_toggle = ~hold_toggle;
    for (int k = 0; k < 10; k++) begin
      if (k % 2 == 0) send_op(OP_ALLOC, 8'($urandom_range(7)), 5'($urandom_range(31)));
      else send_op(OP_FIND, 8'($urandom_range(255)), -5'sd1);
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit no_idle);
    int                roll;
    int                pick;
    int                n_free;
    logic [2:0]        free_list [POOL_SLOTS];
    op_t               op;
    logic [7:0]        idx;
    logic signed [4:0] cur;
    calm = no_idle;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      pick = $urandom_range(99);
      idx  = 8'($urandom_range(7));
      cur  = 5'($urandom_range(31));
      if (roll < 36) begin
        op = OP_ALLOC;
        n_free = 0;
        for (int s = 0; s < POOL_SLOTS; s++)
          if (!slot_used[s]) begin
            free_list[n_free] = 3'(s);
            n_free++;
          end
        if (pick < 15) idx = 8'($urandom_range(255));
        else if (pick < 85 && n_free > 0) idx = {5'd0, free_list[$urandom_range(n_free - 1)]};
      end else if (roll < 66) begin
        op = OP_FREE;
        if (pick < 15) idx = 8'($urandom_range(255));
        else if (pick < 85 && list_len > 0) idx = {5'd0, list_order[$urandom_range(list_len - 1)]};
      end else if (roll < 97) begin
        op = OP_FIND;
        idx = 8'($urandom_range(255));
        if (pick < 75) cur = walk_pos;
      end else begin
        op = OP_CLEAR;
        idx = 8'($urandom_range(255));
      end
      send_op(op, idx, cur);
      // follow the walk; restart it once it runs off the end
      if (op == OP_FIND) walk_pos = (last_result.status == ST_OK) ? last_result.cursor : -5'sd1;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_ALLOC;
    in_ch.slot_index = 8'd0;
    in_ch.cursor     = 5'sd0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      list_order[i] = 3'd0;
    end
    list_len       = 0;
    calm           = 1'b0;
    walk_pos       = -5'sd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pool();
    test_alloc_limits();
    test_find_walk();
    test_free_order();
    test_fill_and_clear();
    test_backpressure();
    test_random_traffic(700, 1'b0);
    test_random_traffic(300, 1'b1);
    test_backpressure();
    test_random_traffic(650, 1'b0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/spool_pkg.sv
src/spool_if.sv
src/spool_cell.sv
src/slot_pool_ordered_active_list.sv
verif/testbench.sv
